FILE: hdl/sh24_pkg.sv
// SipHash-2-4 tag engine: shared types, constants and helpers.
// No dependencies; imported by sh24_round, sh24_ctrl and the top level.

package sh24_pkg;

  // Initialization constants of the four lanes
  localparam logic [63:0] InitA = 64'h736f6d6570736575;
  localparam logic [63:0] InitB = 64'h646f72616e646f6d;
  localparam logic [63:0] InitC = 64'h6c7967656e657261;
  localparam logic [63:0] InitD = 64'h7465646279746573;
  localparam logic [63:0] FinalMark = 64'h00000000000000ff;

  // Rounds per compression and per finalization
  localparam int unsigned CRounds = 2;
  localparam int unsigned DRounds = 4;
  localparam int unsigned CntW = 2;

  // Configuration register indexes
  localparam logic RegKeyLow  = 1'b0;
  localparam logic RegKeyHigh = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_FINAL,
    ST_DONE
  } sh24_state_e;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } sh24_lanes_t;

  // Sequencer -> datapath
  typedef struct packed {
    logic in_ready;
    logic rnd;
    logic abs_end;
    logic tag_ld;
  } sh24_ctl_t;

  // Datapath -> sequencer
  typedef struct packed {
    logic in_fire;
    logic last;
    logic two_abs;
    logic out_free;
  } sh24_sts_t;

  // Byte mask that keeps the low n bytes of a word
  function automatic logic [63:0] tail_mask(logic [2:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (3'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

FILE: hdl/sh24_if.sv
// Valid/ready channel interfaces of the SipHash-2-4 tag engine.
// Depends on nothing; the top level uses one of each.

interface sh24_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_word;

  modport source (output valid, output data_word, output byte_count, output last_word,
                  input ready);
  modport sink   (input valid, input data_word, input byte_count, input last_word,
                  output ready);
endinterface

interface sh24_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] tag;

  modport source (output valid, output tag, input ready);
  modport sink   (input valid, input tag, output ready);
endinterface

FILE: hdl/sh24_round.sv
// One SipRound over the four 64-bit lanes, the shared unit of the engine.
// Depends on sh24_pkg for the lane struct.

module sh24_round import sh24_pkg::*; (
  input  sh24_lanes_t lanes_i,
  output sh24_lanes_t lanes_o
);

  logic [63:0] a1, b1, b2, c1, d1, d2, a2, d3, c2, b3;

  // Two half-rounds, add-rotate-xor on each lane pair
  always_comb begin
    a1 = lanes_i.a + lanes_i.b;
    b1 = {lanes_i.b[50:0], lanes_i.b[63:51]} ^ a1;
    c1 = lanes_i.c + lanes_i.d;
    d1 = {lanes_i.d[47:0], lanes_i.d[63:48]} ^ c1;
    a2 = {a1[31:0], a1[63:32]} + d1;
    d2 = {d1[42:0], d1[63:43]};
    d3 = d2 ^ a2;
    c2 = c1 + b1;
    b2 = {b1[46:0], b1[63:47]};
    b3 = b2 ^ c2;
    lanes_o.a = a2;
    lanes_o.b = b3;
    lanes_o.c = {c2[31:0], c2[63:32]};
    lanes_o.d = d3;
  end

endmodule

FILE: hdl/sh24_ctrl.sv
// Sequencer of the SipHash-2-4 tag engine: counts rounds of the shared unit.
// Depends on sh24_pkg for the state enum and the control structs.

module sh24_ctrl import sh24_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sh24_sts_t sts_i,
  output sh24_ctl_t ctl_o
);

  sh24_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (sts_i.in_fire) state_d = ST_ABSORB;
      end
      ST_ABSORB: begin
        if (cnt_q == CntW'(CRounds - 1)) begin
          cnt_d = '0;
          if (sts_i.two_abs) state_d = ST_ABSORB;
          else if (sts_i.last) state_d = ST_FINAL;
          else state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FINAL: begin
        if (cnt_q == CntW'(DRounds - 1)) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctl_o = '0;
    case (state_q)
      ST_IDLE:   ctl_o.in_ready = 1'b1;
      ST_ABSORB: begin
        ctl_o.rnd     = 1'b1;
        ctl_o.abs_end = (cnt_q == CntW'(CRounds - 1));
      end
      ST_FINAL:  ctl_o.rnd = 1'b1;
      ST_DONE:   ctl_o.tag_ld = sts_i.out_free;
      default:   ctl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: hdl/siphash_2_4_tag.sv
// SipHash-2-4 tag engine, top level: key registers, lanes and output register.
// Depends on sh24_pkg, sh24_if, sh24_round and sh24_ctrl.
//
// Usage: write the 128-bit key through cfg_we_i/cfg_idx_i/cfg_data_i (index 0
// is key bytes 0..7, index 1 bytes 8..15) while the engine is idle; the key is
// sampled when a message starts. Message words enter on in_i, little-endian,
// eight bytes each; the final word has last_word set and byte_count 0..8
// (9..15 act as 8). An empty message is a last word with byte_count 0.
// Each word is taken at intake, then gets two SipRounds, one per cycle on the
// single shared round unit; no new word is taken until they are done. After
// the compression of a last word come four finalization rounds (a full last
// word is compressed before the length word, which gets two rounds too), then
// the tag is loaded into the output register once that register is free.
// One tag per message leaves on out_o. The output register holds the tag while
// the receiver stalls, and the engine keeps taking words for the next message;
// only the next tag waits until the register is free.
// Reset clears the key to zero, drops any pending tag and arms message start.

module siphash_2_4_tag import sh24_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  sh24_in_if.sink     in_i,
  sh24_out_if.source  out_o
);

  logic [63:0] key_lo_q, key_hi_q;
  sh24_lanes_t lanes_q, lanes_d, lanes_base, lanes_rnd;
  logic [63:0] msg_q, msg_d, tail_q, tail_d, tag_q;
  logic [7:0]  len_q, len_d, len_base;
  logic        start_q, start_d, last_q, last_d, two_abs_q, two_abs_d;
  logic        out_valid_q, out_valid_d;
  logic        in_fire, full_word;
  sh24_ctl_t   ctl;
  sh24_sts_t   sts;

  assign in_fire     = in_i.valid & ctl.in_ready;
  assign in_i.ready  = ctl.in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.tag   = tag_q;

  assign sts.in_fire  = in_fire;
  assign sts.last     = last_q;
  assign sts.two_abs  = two_abs_q;
  assign sts.out_free = ~out_valid_q | out_o.ready;

  sh24_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  sh24_round u_round (
    .lanes_i (lanes_q),
    .lanes_o (lanes_rnd)
  );

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKeyLow:  key_lo_q <= cfg_data_i;
        RegKeyHigh: key_hi_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Word intake: length, message word and packed tail
  always_comb begin
    full_word = ~in_i.last_word | in_i.byte_count[3];
    len_base  = start_q ? 8'd0 : len_q;
    len_d     = len_q;
    msg_d     = msg_q;
    tail_d    = tail_q;
    last_d    = last_q;
    two_abs_d = two_abs_q;
    if (in_fire) begin
      len_d     = full_word ? len_base + 8'd8 : len_base + {5'd0, in_i.byte_count[2:0]};
      tail_d    = full_word ? {len_d, 56'd0}
                : ((in_i.data_word & tail_mask(in_i.byte_count[2:0])) | {len_d, 56'd0});
      msg_d     = full_word ? in_i.data_word : tail_d;
      last_d    = in_i.last_word;
      two_abs_d = in_i.last_word & full_word;
    end else if (ctl.abs_end && two_abs_q) begin
      msg_d     = tail_q;
      two_abs_d = 1'b0;
    end
  end

  // Lanes: key load at message start, rounds and the xors around them
  always_comb begin
    lanes_base = lanes_q;
    if (start_q) begin
      lanes_base.a = InitA ^ key_lo_q;
      lanes_base.b = InitB ^ key_hi_q;
      lanes_base.c = InitC ^ key_lo_q;
      lanes_base.d = InitD ^ key_hi_q;
    end
    lanes_d = lanes_q;
    if (in_fire) begin
      lanes_d   = lanes_base;
      lanes_d.d = lanes_base.d ^ msg_d;
    end else if (ctl.rnd) begin
      lanes_d = lanes_rnd;
      if (ctl.abs_end) begin
        lanes_d.a = lanes_rnd.a ^ msg_q;
        if (two_abs_q) lanes_d.d = lanes_rnd.d ^ tail_q;
        else if (last_q) lanes_d.c = lanes_rnd.c ^ FinalMark;
      end
    end
  end

  // Message start flag and output register
  always_comb begin
    start_d = start_q;
    if (in_fire) start_d = 1'b0;
    else if (ctl.abs_end && !two_abs_q && last_q) start_d = 1'b1;
    out_valid_d = out_valid_q;
    if (ctl.tag_ld) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= 1'b1;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      two_abs_q   <= 1'b0;
      len_q       <= '0;
    end else begin
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      two_abs_q   <= two_abs_d;
      len_q       <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    msg_q   <= msg_d;
    tail_q  <= tail_d;
    if (ctl.tag_ld) tag_q <= lanes_q.a ^ lanes_q.b ^ lanes_q.c ^ lanes_q.d;
  end

`ifndef SYNTHESIS
  // A tag is only loaded into a free output register
  a_tag_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.tag_ld |-> (!out_valid_q || out_o.ready))
    else $error("tag loaded over a pending tag");

  // The engine is busy right after taking a word
  a_busy_after_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("word taken while rounds are due");

  // Rounds and intake never share a cycle
  a_round_or_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.rnd && ctl.in_ready))
    else $error("round unit busy during intake");
`endif

endmodule
